// ----- rtl/core/mpe_pkg.sv -----
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and constants for the Mandelbrot pixel escape block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mpe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAXIT  = 3'd2;
    localparam logic [2:0] REG_CRE    = 3'd3;
    localparam logic [2:0] REG_CIM    = 3'd4;
    localparam logic [2:0] REG_SPRE   = 3'd5;
    localparam logic [2:0] REG_SPIM   = 3'd6;
    localparam logic [2:0] REG_ESC    = 3'd7;

    typedef struct packed {
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [15:0]        max_iterations;
        logic signed [31:0] center_real;
        logic signed [31:0] center_imag;
        logic [30:0]        span_real;
        logic [30:0]        span_imag;
        logic [30:0]        escape_limit_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_point;

endpackage
`default_nettype wire

// ----- rtl/core/mpe_map.sv -----
// ----------------------------------------------------------------------------
// mpe_map
// Front end: maps a pixel position to the complex point c, using a
// bit-serial divider for the column and row offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpe_map #(
    parameter int COORD_BITS = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [COORD_BITS-1:0] i_col,
    input  wire [COORD_BITS-1:0] i_row,
    input  mpe_pkg::t_cfg        i_cfg,
    input  wire                  i_full,
    output logic                 o_busy,
    output logic                 o_push,
    output mpe_pkg::t_point      o_point
);
    import mpe_pkg::*;

    localparam int PW = COORD_BITS + 31;
    localparam int SW = PW + 3;
    localparam int CW = $clog2(PW);
    localparam logic [CW-1:0] LAST = CW'(PW - 1);
    localparam logic signed [SW-1:0] QMAX = SW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SW-1:0] QMIN = -SW'(64'sh0000_0000_8000_0000);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]            r_state;
    logic [COORD_BITS-1:0] r_col, r_row;
    logic [PW-1:0]         r_qre, r_qim;
    logic [12:0]           r_rre, r_rim;
    logic [CW-1:0]         r_cnt;
    t_point                r_point;

    logic [12:0]          w_d, h_d;
    logic [13:0]          tre, tim;
    logic                 bre, bim;
    logic signed [SW-1:0] s_re, s_im;

    assign w_d = (i_cfg.image_width  == 13'd0) ? 13'd1 : i_cfg.image_width;
    assign h_d = (i_cfg.image_height == 13'd0) ? 13'd1 : i_cfg.image_height;

    // restoring division step, one quotient bit per cycle
    always_comb begin
        tre = {r_rre, r_qre[PW-1]};
        tim = {r_rim, r_qim[PW-1]};
        bre = (tre >= {1'b0, w_d});
        bim = (tim >= {1'b0, h_d});
        s_re = {{(SW-32){i_cfg.center_real[31]}}, i_cfg.center_real}
             - {{(SW-30){1'b0}}, i_cfg.span_real[30:1]}
             + {3'b000, r_qre};
        s_im = {{(SW-32){i_cfg.center_imag[31]}}, i_cfg.center_imag}
             + {{(SW-30){1'b0}}, i_cfg.span_imag[30:1]}
             - {3'b000, r_qim};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) r_state <= S_MUL;
                S_MUL:  r_state <= S_DIV;
                S_DIV:  if (r_cnt == LAST) r_state <= S_SUM;
                S_SUM:  r_state <= S_PUSH;
                S_PUSH: if (!i_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= i_col;
                r_row <= i_row;
            end
            S_MUL: begin
                r_qre <= PW'(r_col) * PW'(i_cfg.span_real);
                r_qim <= PW'(r_row) * PW'(i_cfg.span_imag);
                r_rre <= '0;
                r_rim <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rre <= bre ? 13'(tre - {1'b0, w_d}) : tre[12:0];
                r_rim <= bim ? 13'(tim - {1'b0, h_d}) : tim[12:0];
                r_qre <= {r_qre[PW-2:0], bre};
                r_qim <= {r_qim[PW-2:0], bim};
                r_cnt <= r_cnt + 1'b1;
            end
            S_SUM: begin
                r_point.re <= (s_re > QMAX) ? 32'sh7FFF_FFFF :
                              (s_re < QMIN) ? 32'sh8000_0000 : s_re[31:0];
                r_point.im <= (s_im > QMAX) ? 32'sh7FFF_FFFF :
                              (s_im < QMIN) ? 32'sh8000_0000 : s_im[31:0];
            end
            default: ;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_point = r_point;

endmodule
`default_nettype wire

// ----- rtl/core/mpe_queue.sv -----
// ----------------------------------------------------------------------------
// mpe_queue
// Two-entry queue of mapped points between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpe_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  mpe_pkg::t_point i_point,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mpe_pkg::t_point o_point
);
    import mpe_pkg::*;

    t_point     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_point;
    end

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_point = r_mem[r_rp];

endmodule
`default_nettype wire

// ----- rtl/core/mpe_iter.sv -----
// ----------------------------------------------------------------------------
// mpe_iter
// Back end: runs z = z*z + c, a multiply state then an update state per step, then the shade divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpe_iter #(
    parameter int SHADE_MAX = 255
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  mpe_pkg::t_cfg   i_cfg,
    input  wire             i_empty,
    input  mpe_pkg::t_point i_point,
    output logic            o_pop,
    output logic            o_done,
    output logic [7:0]      o_shade,
    output logic [15:0]     o_iter_count
);
    import mpe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]         r_state;
    t_point             r_c;
    logic signed [31:0] r_re, r_im;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [15:0]        r_count;
    logic [23:0]        r_sq;
    logic [15:0]        r_srem;
    logic [4:0]         r_scnt;

    logic [63:0]        mag;
    logic               esc;
    logic signed [63:0] t_re, t_im;
    logic [16:0]        trial;
    logic               sbit;
    logic [23:0]        sprod;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)      sat32 = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000) sat32 = 32'sh8000_0000;
        else                                    sat32 = v[31:0];
    endfunction

    always_comb begin
        mag   = 64'(r_rr) + 64'(r_ii);
        esc   = mag > {5'd0, i_cfg.escape_limit_sq, 28'd0};
        t_re  = ((r_rr - r_ii) >>> FRAC_BITS) + 64'(r_c.re);
        t_im  = (r_ri >>> (FRAC_BITS - 1)) + 64'(r_c.im);
        trial = {r_srem, r_sq[23]};
        sbit  = (trial >= {1'b0, i_cfg.max_iterations});
        sprod = 24'(r_count) * 24'(SHADE_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_MUL;
                S_MUL:  r_state <= (r_count >= i_cfg.max_iterations) ? S_DIV : S_UPD;
                S_UPD:  r_state <= esc ? S_DIV : S_MUL;
                S_DIV:  if (r_scnt == 5'd23) r_state <= S_DONE;
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c     <= i_point;
                r_re    <= i_point.re;
                r_im    <= i_point.im;
                r_count <= '0;
            end
            S_MUL: begin
                r_rr   <= r_re * r_re;
                r_ii   <= r_im * r_im;
                r_ri   <= r_re * r_im;
                r_sq   <= sprod;
                r_srem <= '0;
                r_scnt <= '0;
            end
            S_UPD: begin
                r_sq   <= sprod;
                r_srem <= '0;
                r_scnt <= '0;
                if (!esc) begin
                    r_re    <= sat32(t_re);
                    r_im    <= sat32(t_im);
                    r_count <= r_count + 1'b1;
                end
            end
            S_DIV: begin
                r_srem <= sbit ? 16'(trial - {1'b0, i_cfg.max_iterations})
                               : trial[15:0];
                r_sq   <= {r_sq[22:0], sbit};
                r_scnt <= r_scnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_done       = (r_state == S_DONE);
    assign o_shade      = (i_cfg.max_iterations == 16'd0) ? 8'd0 : r_sq[7:0];
    assign o_iter_count = r_count;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_count < i_cfg.max_iterations))
        else $error("step taken at iteration cap");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_shade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_shade <= 8'(SHADE_MAX)))
        else $error("shade above scale");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL))
        else $error("pop without start of iteration");

endmodule
`default_nettype wire

// ----- rtl/core/mandelbrot_pixel_escape_top.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_top
// Escape-time evaluator for one pixel per word, Q4.28 fixed point.
// ----------------------------------------------------------------------------
// A pixel word is taken when start is high and busy low. The front end maps
// it to c (one quotient bit per cycle in the offset divider) and hands it to
// a two-entry queue, waiting while it is full, so it takes the next pixel
// while the back end iterates. Each back end iteration has a multiply state,
// then an add and escape test state; after the last one come the shade
// divide and output. Results appear for one cycle on o_done and cannot be
// stalled.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_pixel_escape_top #(
    parameter int COORD_BITS = 12,
    parameter int SHADE_MAX  = 255
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire [COORD_BITS-1:0] i_pixel_col,
    input  wire [COORD_BITS-1:0] i_pixel_row,
    output logic                 o_done,
    output logic [7:0]           o_shade,
    output logic [15:0]          o_iter_count,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [4:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mpe_pkg::*;

    t_cfg       r_cfg;
    t_point     push_pt, head_pt;
    logic       push, pop, full, empty;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= 13'd1024;
            r_cfg.image_height    <= 13'd1024;
            r_cfg.max_iterations  <= 16'd256;
            r_cfg.center_real     <= -32'sd134217728;
            r_cfg.center_imag     <= 32'sd0;
            r_cfg.span_real       <= 31'd805306368;
            r_cfg.span_imag       <= 31'd536870912;
            r_cfg.escape_limit_sq <= 31'd1073741824;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_WIDTH:  r_cfg.image_width     <= pwdata[12:0];
                REG_HEIGHT: r_cfg.image_height    <= pwdata[12:0];
                REG_MAXIT:  r_cfg.max_iterations  <= pwdata[15:0];
                REG_CRE:    r_cfg.center_real     <= pwdata;
                REG_CIM:    r_cfg.center_imag     <= pwdata;
                REG_SPRE:   r_cfg.span_real       <= pwdata[30:0];
                REG_SPIM:   r_cfg.span_imag       <= pwdata[30:0];
                REG_ESC:    r_cfg.escape_limit_sq <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = {19'd0, r_cfg.image_width};
            REG_HEIGHT: prdata = {19'd0, r_cfg.image_height};
            REG_MAXIT:  prdata = {16'd0, r_cfg.max_iterations};
            REG_CRE:    prdata = r_cfg.center_real;
            REG_CIM:    prdata = r_cfg.center_imag;
            REG_SPRE:   prdata = {1'b0, r_cfg.span_real};
            REG_SPIM:   prdata = {1'b0, r_cfg.span_imag};
            REG_ESC:    prdata = {1'b0, r_cfg.escape_limit_sq};
            default:    prdata = '0;
        endcase
    end

    mpe_map #(.COORD_BITS(COORD_BITS)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_col   (i_pixel_col),
        .i_row   (i_pixel_row),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_point (push_pt)
    );

    mpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_pt),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_point (head_pt)
    );

    mpe_iter #(.SHADE_MAX(SHADE_MAX)) u_iter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (empty),
        .i_point      (head_pt),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_shade      (o_shade),
        .o_iter_count (o_iter_count)
    );

endmodule
`default_nettype wire

// ----- bench/mandelbrot_pixel_escape_top_tb.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_top_tb
// Self-checking bench: pixel words go in on start/busy, views are set over APB,
// and each shade/count word must match a typed row or fixed-point escape model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mandelbrot_pixel_escape_top_tb;
    import mpe_pkg::*;

    localparam int      SHADE_SCALE = 255;
    localparam int      CYCLE_LIMIT = 4000000;
    localparam longint  Q_HI        = 64'sd2147483647;
    localparam longint  Q_LO        = -64'sd2147483648;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [2:0] reg_idx;
        logic [31:0] value;
        logic [11:0] col;
        logic [11:0] row;
        bit         typed;
        logic [7:0] shade;
        logic [15:0] iters;
    } t_row;

    typedef struct packed {
        logic [7:0]  shade;
        logic [15:0] iters;
    } t_pixel_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_pixel_col;
    logic [11:0] i_pixel_row;
    logic        o_done;
    logic [7:0]  o_shade;
    logic [15:0] o_iter_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_cfg        view;
    t_pixel_out  pending_pixels[$];
    int          mismatch_cnt;
    int          cycle_cnt;
    bit          no_gaps;

    mandelbrot_pixel_escape_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .o_done       (o_done),
        .o_shade      (o_shade),
        .o_iter_count (o_iter_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // Escape-time count and shade for one pixel under the current view.
    function automatic t_pixel_out escape_pixel(input logic [11:0] col, input logic [11:0] row);
        longint unsigned w, h, off_re, off_im, mag, lim, n;
        longint          c_re, c_im, re, im, rr, ii, nre, nim;
        t_pixel_out      res;
        w = (view.image_width == 0) ? 1 : longint'(view.image_width);
        h = (view.image_height == 0) ? 1 : longint'(view.image_height);
        off_re = (longint'(col) * longint'(view.span_real)) / w;
        off_im = (longint'(row) * longint'(view.span_imag)) / h;
        c_re = clamp_q(longint'(view.center_real) - longint'(view.span_real >> 1)
                       + longint'(off_re));
        c_im = clamp_q(longint'(view.center_imag) + longint'(view.span_imag >> 1)
                       - longint'(off_im));
        lim = longint'(view.escape_limit_sq) << FRAC_BITS;
        re = c_re;
        im = c_im;
        n = 0;
        while (n < view.max_iterations) begin
            rr = re * re;
            ii = im * im;
            mag = longint'(rr) + longint'(ii);
            if (mag > lim) break;
            nre = clamp_q(((rr - ii) >>> FRAC_BITS) + c_re);
            nim = clamp_q(((re * im) >>> (FRAC_BITS - 1)) + c_im);
            re = nre;
            im = nim;
            n++;
        end
        res.iters = n[15:0];
        res.shade = (view.max_iterations == 0) ? 8'd0 : 8'((n * SHADE_SCALE) / view.max_iterations);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Result words cannot be held off; check each one as it appears.
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected word, iter_count", o_iter_count, -1);
            end else begin
                want = pending_pixels.pop_front();
                if (o_iter_count !== want.iters)
                    report_mismatch("iter_count", o_iter_count, want.iters);
                if (o_shade !== want.shade)
                    report_mismatch("shade", o_shade, want.shade);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic drain_results;
        start = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        start   = 1'b0;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_WIDTH:  view.image_width     = value[12:0];
            REG_HEIGHT: view.image_height    = value[12:0];
            REG_MAXIT:  view.max_iterations  = value[15:0];
            REG_CRE:    view.center_real     = value;
            REG_CIM:    view.center_imag     = value;
            REG_SPRE:   view.span_real       = value[30:0];
            REG_SPIM:   view.span_imag       = value[30:0];
            REG_ESC:    view.escape_limit_sq = value[30:0];
            default: ;
        endcase
    endtask

    // Called at a falling edge; leaves start high after acceptance.
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input bit typed, input t_pixel_out typed_out);
        int gap;
        t_pixel_out want;
        if (!no_gaps && $urandom_range(99) < 35) begin
            gap = $urandom_range(1, 6);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       = 1'b1;
        i_pixel_col = col;
        i_pixel_row = row;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        want = typed ? typed_out : escape_pixel(col, row);
        if (typed && want != escape_pixel(col, row))
            $display("note: typed row differs from predictor at col %0d row %0d", col, row);
        pending_pixels.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic random_view;
        int pick;
        pick = $urandom_range(9);
        write_reg(REG_WIDTH, pick == 0 ? 32'd0 : pick == 1 ? 32'd4096 : pick == 2 ? 32'd1
                             : $urandom_range(1, 4096));
        pick = $urandom_range(9);
        write_reg(REG_HEIGHT, pick == 0 ? 32'd0 : pick == 1 ? 32'd4096 : pick == 2 ? 32'd1
                              : $urandom_range(1, 4096));
        pick = $urandom_range(19);
        write_reg(REG_MAXIT, pick == 0 ? 32'd0 : pick == 1 ? 32'd1 : pick == 2 ? 32'd255
                             : $urandom_range(2, 48));
        pick = $urandom_range(9);
        write_reg(REG_CRE, pick == 0 ? $urandom : 32'($signed($urandom_range(0, 32'h3000_0000))
                                                      - 32'sh2000_0000));
        write_reg(REG_CIM, pick == 0 ? $urandom : 32'($signed($urandom_range(0, 32'h2000_0000))
                                                      - 32'sh1000_0000));
        write_reg(REG_SPRE, pick == 0 ? ($urandom & 32'h7fff_ffff)
                                      : $urandom_range(1, 32'h4000_0000));
        write_reg(REG_SPIM, pick == 0 ? ($urandom & 32'h7fff_ffff)
                                      : $urandom_range(1, 32'h4000_0000));
        pick = $urandom_range(9);
        write_reg(REG_ESC, pick == 0 ? ($urandom & 32'h7fff_ffff)
                           : pick == 1 ? 32'h7fff_ffff : 32'h4000_0000);
    endtask

    t_row steps[] = '{
        // default view: top-left corner is -2+1i, out at once
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd0,    12'd0,    1, 8'd0,   16'd0},
        // center -0.5+0i never leaves the set
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd512,  12'd512,  1, 8'd255, 16'd256},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd4095, 12'd4095, 0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd4095, 12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd0,    12'd4095, 0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd700,  12'd300,  0, 8'd0,   16'd0},
        '{ROW_WRITE, REG_MAXIT, 0, 12'd0,    12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd512,  12'd512,  1, 8'd0,   16'd0},
        '{ROW_WRITE, REG_MAXIT, 32'hffff, 12'd0, 12'd0, 0, 8'd0,  16'd0},
        '{ROW_WRITE, REG_ESC,   0, 12'd0,    12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd0,    12'd0,    1, 8'd0,   16'd0},
        // c = 0 exactly: runs to the full cap
        '{ROW_WRITE, REG_CRE,   0, 12'd0,    12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd512,  12'd512,  1, 8'd255, 16'hffff},
        '{ROW_WRITE, REG_ESC,   32'h7fff_ffff, 12'd0, 12'd0, 0, 8'd0, 16'd0},
        '{ROW_WRITE, REG_MAXIT, 32'd20, 12'd0, 12'd0,  0, 8'd0,   16'd0},
        '{ROW_WRITE, REG_WIDTH, 0, 12'd0,    12'd0,    0, 8'd0,   16'd0},
        '{ROW_WRITE, REG_HEIGHT, 0, 12'd0,   12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd4095, 12'd4095, 0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd1,    12'd0,    0, 8'd0,   16'd0},
        // saturating view
        '{ROW_WRITE, REG_CRE,  32'h7fff_ffff, 12'd0, 12'd0, 0, 8'd0, 16'd0},
        '{ROW_WRITE, REG_CIM,  32'h8000_0000, 12'd0, 12'd0, 0, 8'd0, 16'd0},
        '{ROW_WRITE, REG_SPRE, 32'h7fff_ffff, 12'd0, 12'd0, 0, 8'd0, 16'd0},
        '{ROW_WRITE, REG_SPIM, 32'h7fff_ffff, 12'd0, 12'd0, 0, 8'd0, 16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd0,    12'd0,    0, 8'd0,   16'd0},
        '{ROW_PIXEL, REG_WIDTH, 0, 12'd4095, 12'd4095, 0, 8'd0,   16'd0}
    };

    initial begin
        t_pixel_out typed_out;
        int         n_items;
        logic [11:0] col, row;
        int         wmax, hmax;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        no_gaps      = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_pixel_col  = '0;
        i_pixel_row  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        view.image_width     = 13'd1024;
        view.image_height    = 13'd1024;
        view.max_iterations  = 16'd256;
        view.center_real     = -32'sd134217728;
        view.center_imag     = 32'sd0;
        view.span_real       = 31'd805306368;
        view.span_imag       = 31'd536870912;
        view.escape_limit_sq = 31'd1073741824;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (steps[k]) begin
            if (steps[k].kind == ROW_WRITE) begin
                drain_results();
                write_reg(steps[k].reg_idx, steps[k].value);
            end else begin
                typed_out.shade = steps[k].shade;
                typed_out.iters = steps[k].iters;
                send_pixel(steps[k].col, steps[k].row, steps[k].typed, typed_out);
            end
        end

        n_items = 0;
        typed_out = '{default: '0};
        while (n_items < 1900) begin
            drain_results();
            random_view();
            @(negedge i_clk);
            wmax = (view.image_width == 0) ? 0 : view.image_width - 1;
            hmax = (view.image_height == 0) ? 0 : view.image_height - 1;
            repeat (150) begin
                no_gaps = (n_items >= 700 && n_items < 1000);
                if ($urandom_range(9) == 0) begin
                    col = 12'($urandom_range(0, 4095));
                    row = 12'($urandom_range(0, 4095));
                end else begin
                    col = 12'($urandom_range(0, wmax > 4095 ? 4095 : wmax));
                    row = 12'($urandom_range(0, hmax > 4095 ? 4095 : hmax));
                end
                send_pixel(col, row, 0, typed_out);
                n_items++;
            end
        end
        start = 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- mandelbrot_pixel_escape_top.f -----
rtl/core/mpe_pkg.sv
rtl/core/mpe_map.sv
rtl/core/mpe_queue.sv
rtl/core/mpe_iter.sv
rtl/core/mandelbrot_pixel_escape_top.sv
bench/mandelbrot_pixel_escape_top_tb.sv
